>>> rtl/core/itay_pkg.sv
// itay_pkg: shared types and constants for the tilt and yaw integrator
// no dependencies

package itay_pkg;

    localparam int CordicSteps = 18;
    localparam int CordicW     = 36;
    localparam int AngleLimit  = 11520;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SQRT  = 7'b0000010,
        S_CORD  = 7'b0000100,
        S_ANGLE = 7'b0001000,
        S_NEXT  = 7'b0010000,
        S_YAW   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    typedef struct packed {
        logic load;
        logic sqrt_start;
        logic sqrt_step;
        logic cord_init;
        logic cord_step;
        logic store_angle;
        logic sel_roll;
        logic yaw_mul;
        logic yaw_acc;
    } t_cmd;

    typedef struct packed {
        logic sqrt_done;
        logic cord_done;
    } t_stat;

    function automatic logic [31:0] atan_entry(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'd2949120;
            5'd1:  v = 32'd1740967;
            5'd2:  v = 32'd919879;
            5'd3:  v = 32'd466945;
            5'd4:  v = 32'd234379;
            5'd5:  v = 32'd117304;
            5'd6:  v = 32'd58666;
            5'd7:  v = 32'd29335;
            5'd8:  v = 32'd14668;
            5'd9:  v = 32'd7334;
            5'd10: v = 32'd3667;
            5'd11: v = 32'd1833;
            5'd12: v = 32'd917;
            5'd13: v = 32'd458;
            5'd14: v = 32'd229;
            5'd15: v = 32'd115;
            5'd16: v = 32'd57;
            5'd17: v = 32'd29;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/imu_tilt_and_yaw_integrator.sv
// imu_tilt_and_yaw_integrator: top level, gyro scale register and wiring
// depends on itay_pkg, itay_ctrl, itay_dp
//
// input word: raw accel x/y/z, gyro z, status byte and elapsed microseconds on
// i_in_valid / o_in_ready. status bit 0 replaces the held accel samples, bit 1
// the held gyro z. output word: pitch and roll in 1/128 degree and the yaw
// accumulator in 2^-24 degree on o_out_valid / i_out_ready.
// one word is in flight at a time: pitch and roll each take a bit-by-bit square
// root and a pass through the shared cordic loop; o_out_valid rises once both
// angles and the yaw product are ready, and the next input is taken in the cycle
// after the output word is accepted.
// the user must write gyro_scale through i_cfg_we / i_cfg_data only while idle;
// the block does not enforce it.
// reset clears the held samples, the yaw accumulator and sets gyro_scale to 9621.
// a stalled receiver holds the output word and the block takes no new input.

module imu_tilt_and_yaw_integrator #(
    parameter logic [15:0] ScaleReset = 16'd9621
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_gyro_z,
    input  logic [7:0]         i_status_byte,
    input  logic [19:0]        i_elapsed_us,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [14:0] o_pitch_angle,
    output logic signed [14:0] o_roll_angle,
    output logic signed [47:0] o_yaw_angle,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data
);

    logic [15:0] r_gyro_scale;
    itay_pkg::t_cmd  cmd;
    itay_pkg::t_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_gyro_scale <= ScaleReset;
        else if (i_cfg_we) r_gyro_scale <= i_cfg_data;
    end

    itay_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    itay_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_accel_x     (i_accel_x),
        .i_accel_y     (i_accel_y),
        .i_accel_z     (i_accel_z),
        .i_gyro_z      (i_gyro_z),
        .i_status_byte (i_status_byte),
        .i_elapsed_us  (i_elapsed_us),
        .i_gyro_scale  (r_gyro_scale),
        .o_pitch_angle (o_pitch_angle),
        .o_roll_angle  (o_roll_angle),
        .o_yaw_angle   (o_yaw_angle)
    );

endmodule

>>> rtl/core/itay_ctrl.sv
// itay_ctrl: sequencer for the tilt and yaw integrator
// depends on itay_pkg

module itay_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  itay_pkg::t_stat i_stat,
    output itay_pkg::t_cmd  o_cmd
);

    itay_pkg::t_state r_state, n_state;
    logic r_roll, n_roll;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itay_pkg::S_IDLE;
            r_roll  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_roll  <= n_roll;
        end
    end

    always_comb begin
        n_state = r_state;
        n_roll  = r_roll;
        o_cmd   = '0;
        o_cmd.sel_roll = r_roll;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            itay_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_roll  = 1'b0;
                    n_state = itay_pkg::S_SQRT;
                end
            end
            itay_pkg::S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_stat.sqrt_done) begin
                    o_cmd.sqrt_step = 1'b0;
                    o_cmd.cord_init = 1'b1;
                    n_state = itay_pkg::S_CORD;
                end
            end
            itay_pkg::S_CORD: begin
                o_cmd.cord_step = 1'b1;
                if (i_stat.cord_done) begin
                    o_cmd.cord_step = 1'b0;
                    n_state = itay_pkg::S_ANGLE;
                end
            end
            itay_pkg::S_ANGLE: begin
                o_cmd.store_angle = 1'b1;
                n_state = r_roll ? itay_pkg::S_YAW : itay_pkg::S_NEXT;
            end
            itay_pkg::S_NEXT: begin
                n_roll = 1'b1;
                o_cmd.sel_roll = 1'b1;
                o_cmd.sqrt_start = 1'b1;
                n_state = itay_pkg::S_SQRT;
            end
            itay_pkg::S_YAW: begin
                o_cmd.yaw_mul = 1'b1;
                n_state = itay_pkg::S_OUT;
            end
            itay_pkg::S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.yaw_acc = 1'b1;
                    n_state = itay_pkg::S_IDLE;
                end
            end
            default: n_state = itay_pkg::S_IDLE;
        endcase
    end

endmodule

>>> rtl/core/itay_dp.sv
// itay_dp: held samples, square root, cordic and yaw datapath
// depends on itay_pkg

module itay_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  itay_pkg::t_cmd     i_cmd,
    output itay_pkg::t_stat    o_stat,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_gyro_z,
    input  logic [7:0]         i_status_byte,
    input  logic [19:0]        i_elapsed_us,
    input  logic [15:0]        i_gyro_scale,
    output logic signed [14:0] o_pitch_angle,
    output logic signed [14:0] o_roll_angle,
    output logic signed [47:0] o_yaw_angle
);

    localparam int W = itay_pkg::CordicW;

    logic signed [15:0] r_ax, r_ay, r_az, r_gz;
    logic [19:0]        r_dt;
    logic [47:0]        r_yaw;
    logic signed [35:0] r_gdt;
    logic signed [52:0] r_prod;
    logic signed [14:0] r_pitch, r_roll;

    // square root state
    logic [31:0] r_rem;
    logic [16:0] r_root;
    logic [4:0]  r_scnt;
    // sqrt copies sq_sum into this source register on start
    logic [31:0] r_sq;
    // cordic state
    logic signed [W-1:0] r_cx, r_cy;
    logic signed [31:0]  r_z;
    logic [4:0]          r_ccnt;
    logic                r_zero;
    logic signed [16:0]  r_num;

    logic signed [15:0] a_sel, b_sel;
    logic signed [16:0] num_sel;
    logic signed [31:0] a_sq, b_sq;
    logic [31:0]        sq_sum;
    logic [33:0]        trial;
    logic [31:0]        rem_sh;
    logic signed [W-1:0] dx, dy;
    logic signed [31:0]  zr;
    logic signed [22:0]  ang;
    logic signed [14:0]  ang_sat;
    logic signed [15:0] ax_n, ay_n, az_n;
    logic signed [47:0] yaw_inc;

    assign ax_n = i_status_byte[0] ? i_accel_x : r_ax;
    assign ay_n = i_status_byte[0] ? i_accel_y : r_ay;
    assign az_n = i_status_byte[0] ? i_accel_z : r_az;

    always_comb begin
        if (i_cmd.sel_roll) begin
            a_sel   = r_ay;
            num_sel = -{r_ax[15], r_ax};
        end else begin
            a_sel   = r_ax;
            num_sel = {r_ay[15], r_ay};
        end
        b_sel  = r_az;
        a_sq   = a_sel * a_sel;
        b_sq   = b_sel * b_sel;
        sq_sum = $unsigned(a_sq) + $unsigned(b_sq);
    end

    // one result bit per step, 16 steps
    assign rem_sh = {r_rem[29:0], r_sq[31:30]};
    assign trial  = {2'b00, rem_sh} - {r_root[15:0], 2'b01};

    assign dx = r_cx >>> r_ccnt;
    assign dy = r_cy >>> r_ccnt;

    assign zr  = r_z + 32'sd256;
    assign ang = 23'(zr >>> 9);
    always_comb begin
        if (ang > 23'sd11520)       ang_sat = 15'sd11520;
        else if (ang < -23'sd11520) ang_sat = -15'sd11520;
        else                        ang_sat = ang[14:0];
    end

    assign o_stat = {(r_scnt == 5'd16), (r_ccnt == 5'(itay_pkg::CordicSteps))};

    assign yaw_inc = 48'($signed(r_prod[52:16]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax <= '0; r_ay <= '0; r_az <= '0; r_gz <= '0;
            r_yaw <= '0;
        end else begin
            if (i_cmd.load) begin
                r_ax <= ax_n;
                r_ay <= ay_n;
                r_az <= az_n;
                if (i_status_byte[1]) r_gz <= i_gyro_z;
            end
            if (i_cmd.yaw_acc)
                r_yaw <= r_yaw + yaw_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dt   <= i_elapsed_us;
        end
        if (i_cmd.load || i_cmd.sqrt_start) begin
            r_scnt <= 5'd31;
        end else if (r_scnt == 5'd31) begin
            r_sq   <= sq_sum;
            r_num  <= num_sel;
            r_rem  <= '0;
            r_root <= '0;
            r_scnt <= 5'd0;
        end else if (i_cmd.sqrt_step && r_scnt != 5'd16) begin
            if (!trial[33]) begin
                r_rem  <= trial[31:0];
                r_root <= {r_root[15:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[15:0], 1'b0};
            end
            r_sq   <= {r_sq[29:0], 2'b00};
            r_scnt <= r_scnt + 5'd1;
        end
        if (i_cmd.cord_init) begin
            r_cx   <= W'({19'd0, r_root[16:0]}) <<< 14;
            r_cy   <= W'(r_num) <<< 14;
            r_z    <= '0;
            r_ccnt <= '0;
            r_zero <= (r_root == '0) && (r_num == '0);
        end else if (i_cmd.cord_step && !o_stat.cord_done) begin
            if (!r_cy[W-1]) begin
                r_cx <= r_cx + dy;
                r_cy <= r_cy - dx;
                r_z  <= r_z + $signed(itay_pkg::atan_entry(r_ccnt));
            end else begin
                r_cx <= r_cx - dy;
                r_cy <= r_cy + dx;
                r_z  <= r_z - $signed(itay_pkg::atan_entry(r_ccnt));
            end
            r_ccnt <= r_ccnt + 5'd1;
        end
        if (i_cmd.store_angle) begin
            if (i_cmd.sel_roll) r_roll  <= r_zero ? '0 : ang_sat;
            else                r_pitch <= r_zero ? '0 : ang_sat;
        end
        if (i_cmd.cord_init)
            r_gdt <= r_gz * $signed({1'b0, r_dt});
        if (i_cmd.yaw_mul)
            r_prod <= r_gdt * $signed({1'b0, i_gyro_scale}) + 53'sd32768;
    end

    assign o_pitch_angle = r_pitch;
    assign o_roll_angle  = r_roll;
    assign o_yaw_angle   = r_yaw + yaw_inc;

endmodule
